[hdl/isrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package isrc_pkg;

  localparam logic [7:0]  APP2_CODE        = 8'hE2;
  localparam logic [15:0] ICC_HEADER_BYTES = 16'd14;

  // request kinds carried on s_tuser
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_NO_PROFILE     = 3'd1;
  localparam logic [2:0] ST_COUNT_MISMATCH = 3'd2;
  localparam logic [2:0] ST_BAD_SEQ        = 3'd3;
  localparam logic [2:0] ST_DUPLICATE      = 3'd4;
  localparam logic [2:0] ST_MISSING        = 3'd5;
  localparam logic [2:0] ST_EMPTY          = 3'd6;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_ACC  = 5'b00100,
    S_LOOK = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

[hdl/icc_segment_reassembly_check.sv]
// add returns no result; finish goes straight to S_PUT on a latched error or
//   no profile, else it walks the segments, each via S_RD then S_ACC, up to a hole
//   (the walk reads one length entry in S_RD, writes one offset entry in S_ACC)
// lookup reaches S_PUT directly or via S_LOOK; one request is in work at a time
// the output register holds a result while the next request is already taken
// rst (synchronous, active high) clears seen flags, count, error, total and handshake
`timescale 1ns / 1ps
`default_nettype none
module icc_segment_reassembly_check
  import isrc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 255
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // marker_code[7:0], id_match[8], marker_length[24:9], seq_number[32:25],
  // segment_count[40:33], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // action[1:0]
  input  wire logic [1:0]            s_tuser,
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // status[2:0], profile_size[26:3], segment_offset[50:27],
  // segment_length[66:51], zero fill above
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int IDX_W = (MAX_SEGMENTS < 2) ? 1 : $clog2(MAX_SEGMENTS + 1);
  localparam int DEPTH = 2 ** IDX_W;
  localparam logic [7:0] MAX_SEQ = 8'(MAX_SEGMENTS);

  // request fields
  logic [1:0]  action;
  logic [7:0]  marker_code;
  logic        id_match;
  logic [15:0] marker_length;
  logic [7:0]  seq_number;
  logic [7:0]  segment_count;

  assign action        = s_tuser;
  assign marker_code   = s_tdata[7:0];
  assign id_match      = s_tdata[8];
  assign marker_length = s_tdata[24:9];
  assign seq_number    = s_tdata[32:25];
  assign segment_count = s_tdata[40:33];

  // control state
  state_t           state;
  logic [7:0]       expected_count;
  logic [2:0]       latched_error;
  logic [23:0]      running_total;
  logic [DEPTH-1:0] seen;
  logic [7:0]       walk_idx;
  logic [23:0]      walk_total;

  // staged result
  logic [2:0]  res_status;
  logic [23:0] res_total;
  logic [23:0] res_offset;
  logic [15:0] res_length;

  // per-segment stores, one read port each with registered data
  logic [15:0] length_mem [DEPTH];
  logic [23:0] offset_mem [DEPTH];
  logic [15:0] rd_length;
  logic [23:0] rd_offset;
  logic [IDX_W-1:0] rd_addr;

  logic transfer_in;
  assign s_tready    = (state == S_IDLE);
  assign transfer_in = s_tvalid && s_tready;

  // add decode
  logic       is_icc;
  logic [7:0] eff_count;
  logic       count_bad;
  logic       seq_bad;
  logic       seq_dup;
  logic       add_ok;

  assign is_icc    = (marker_code == APP2_CODE) && id_match &&
                     (marker_length >= ICC_HEADER_BYTES);
  assign eff_count = (expected_count == 8'd0) ? segment_count : expected_count;
  assign count_bad = (expected_count != 8'd0) && (expected_count != segment_count);
  assign seq_bad   = (seq_number == 8'd0) || (seq_number > eff_count) ||
                     (seq_number > MAX_SEQ);
  assign seq_dup   = seen[seq_number[IDX_W-1:0]];
  assign add_ok    = transfer_in && (action == ACT_ADD) && is_icc &&
                     (latched_error == ST_OK) && !count_bad && !seq_bad && !seq_dup;

  // walk step
  logic [23:0] walk_total_next;
  logic        walk_hole;
  assign walk_total_next = walk_total + {8'd0, rd_length};
  assign walk_hole = (walk_idx > MAX_SEQ) || !seen[walk_idx[IDX_W-1:0]];

  // lookup range check
  logic look_bad;
  assign look_bad = (seq_number == 8'd0) || (seq_number > expected_count);

  // walk uses the running index, requests use their own sequence number
  assign rd_addr = (state == S_IDLE) ? seq_number[IDX_W-1:0] : walk_idx[IDX_W-1:0];

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    rd_length <= length_mem[rd_addr];
    rd_offset <= offset_mem[rd_addr];
    if (add_ok) begin
      length_mem[seq_number[IDX_W-1:0]] <= marker_length - ICC_HEADER_BYTES;
    end
    if (state == S_ACC) begin
      offset_mem[walk_idx[IDX_W-1:0]] <= walk_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      expected_count <= 8'd0;
      latched_error  <= ST_OK;
      running_total  <= 24'd0;
      seen           <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // in S_PUT a new result takes over the output register instead
      if (m_tvalid && m_tready && (state != S_PUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (transfer_in) begin
            case (action)
              ACT_ADD: begin
                // any add voids an earlier finish
                running_total <= 24'd0;
                if (is_icc && latched_error == ST_OK) begin
                  if (count_bad) begin
                    latched_error <= ST_COUNT_MISMATCH;
                  end else begin
                    expected_count <= eff_count;
                    if (seq_bad) begin
                      latched_error <= ST_BAD_SEQ;
                    end else if (seq_dup) begin
                      latched_error <= ST_DUPLICATE;
                    end else begin
                      seen[seq_number[IDX_W-1:0]] <= 1'b1;
                    end
                  end
                end
              end
              ACT_FINISH: begin
                running_total <= 24'd0;
                res_total     <= 24'd0;
                res_offset    <= 24'd0;
                res_length    <= 16'd0;
                walk_idx      <= 8'd1;
                walk_total    <= 24'd0;
                if (latched_error != ST_OK) begin
                  res_status <= latched_error;
                  state      <= S_PUT;
                end else if (expected_count == 8'd0) begin
                  res_status <= ST_NO_PROFILE;
                  state      <= S_PUT;
                end else begin
                  state <= S_RD;
                end
              end
              ACT_LOOKUP: begin
                res_total  <= 24'd0;
                res_offset <= 24'd0;
                res_length <= 16'd0;
                if (running_total == 24'd0) begin
                  res_status <= ST_NO_PROFILE;
                  state      <= S_PUT;
                end else if (look_bad) begin
                  res_status <= ST_BAD_SEQ;
                  state      <= S_PUT;
                end else begin
                  state <= S_LOOK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          // length entry read is in flight, check the seen flag meanwhile
          if (walk_hole) begin
            res_status <= ST_MISSING;
            state      <= S_PUT;
          end else begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          walk_total <= walk_total_next;
          if (walk_idx == expected_count) begin
            if (walk_total_next == 24'd0) begin
              res_status <= ST_EMPTY;
            end else begin
              res_status    <= ST_OK;
              res_total     <= walk_total_next;
              running_total <= walk_total_next;
            end
            state <= S_PUT;
          end else begin
            walk_idx <= walk_idx + 8'd1;
            state    <= S_RD;
          end
        end
        S_LOOK: begin
          res_status <= ST_OK;
          res_total  <= running_total;
          res_offset <= rd_offset;
          res_length <= rd_length;
          state      <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, res_length, res_offset, res_total, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/isrc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module isrc_checker
  import isrc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [1:0]            s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // failed results carry no total, offset or length
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[66:3] == 64'd0))
    else $error("nonzero payload on failing status");

  // an add transfer on an empty output never produces a result next cycle
  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_ADD) && !m_tvalid |=> !m_tvalid)
    else $error("result appeared after an add");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd7))
    else $error("undefined status code");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind icc_segment_reassembly_check isrc_checker u_isrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
